### hdl/polygon_area_volume_accumulator_top_defines.svh
// Assertion macros for the polygon area and volume accumulator
`ifndef POLYGON_AREA_VOLUME_ACCUMULATOR_TOP_DEFINES_SVH
`define POLYGON_AREA_VOLUME_ACCUMULATOR_TOP_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent
`define PAVA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that the consequent holds in the cycle after the antecedent
`define PAVA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/pava_pkg.sv
package pava_pkg;

  localparam int unsigned COORD_W   = 24;
  localparam int unsigned THICK_W   = 16;
  localparam int unsigned CROSS_W   = 59;
  localparam int unsigned CROSS_X_W = CROSS_W + 2;
  localparam int unsigned AREA_W    = 57;
  localparam int unsigned VOL_W     = 63;
  localparam int unsigned LO_W      = 29;
  localparam int unsigned HI_W      = AREA_W - LO_W;
  localparam int unsigned MUL_A_W   = 30;
  localparam int unsigned MUL_B_W   = 25;
  localparam int unsigned MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int unsigned FULL_W    = AREA_W + THICK_W;

  localparam logic [CROSS_W-1:0] CROSS_MAX = {1'b0, {(CROSS_W-1){1'b1}}};
  localparam logic [CROSS_W-1:0] CROSS_MIN = {1'b1, {(CROSS_W-1){1'b0}}};
  localparam logic [AREA_W-1:0]  AREA_MAX  = {AREA_W{1'b1}};
  localparam logic [VOL_W-1:0]   VOL_MAX   = {VOL_W{1'b1}};

  typedef enum logic [1:0] {
    MUL_PX_Y,
    MUL_X_PY,
    MUL_AREA_LO,
    MUL_AREA_HI
  } mul_sel_e;

  typedef struct packed {
    logic     take_first;
    logic     take_next;
    logic     clr_vol;
    mul_sel_e mul_sel;
    logic     p_ld;
    logic     cross_upd;
    logic     area_ld;
    logic     vp_ld;
    logic     vol_ld;
  } pava_cmd_t;

  typedef struct packed {
    logic closes;
  } pava_sts_t;

endpackage

### hdl/pava_dp.sv
module pava_dp import pava_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  pava_cmd_t                 cmd_i,
  output pava_sts_t                 sts_o,
  input  logic signed [COORD_W-1:0] coord_x_i,
  input  logic signed [COORD_W-1:0] coord_y_i,
  input  logic [THICK_W-1:0]        thickness_i,
  output logic [AREA_W-1:0]         polygon_area_o,
  output logic [VOL_W-1:0]          volume_total_o
);

  logic signed [COORD_W-1:0] first_x_q, first_y_q, prev_x_q, prev_y_q, cur_x_q, cur_y_q;
  logic [THICK_W-1:0]        thick_q;
  logic [CROSS_W-1:0]        cross_q, cross_d;
  logic [AREA_W-1:0]         area_q, area_d;
  logic signed [MUL_P_W-1:0] p_q;
  logic [VOL_W-1:0]          vp_q, vp_d;
  logic [VOL_W-1:0]          vol_q, vol_d;
  logic [AREA_W-1:0]         area_out_q;
  logic [VOL_W-1:0]          vol_out_q;

  logic signed [MUL_A_W-1:0]   mul_a;
  logic signed [MUL_B_W-1:0]   mul_b;
  logic signed [MUL_P_W-1:0]   mul_p;
  logic signed [CROSS_X_W-1:0] cross_wide;
  logic [CROSS_W-1:0]          cross_mag;
  logic [CROSS_W-2:0]          half;
  logic [FULL_W-1:0]           full;
  logic [VOL_W:0]              vol_sum;

  always_comb begin
    case (cmd_i.mul_sel)
      MUL_PX_Y: begin
        mul_a = {{(MUL_A_W-COORD_W){prev_x_q[COORD_W-1]}}, prev_x_q};
        mul_b = {{(MUL_B_W-COORD_W){coord_y_i[COORD_W-1]}}, coord_y_i};
      end
      MUL_X_PY: begin
        mul_a = {{(MUL_A_W-COORD_W){cur_x_q[COORD_W-1]}}, cur_x_q};
        mul_b = {{(MUL_B_W-COORD_W){prev_y_q[COORD_W-1]}}, prev_y_q};
      end
      MUL_AREA_LO: begin
        mul_a = {{(MUL_A_W-LO_W){1'b0}}, area_q[LO_W-1:0]};
        mul_b = {{(MUL_B_W-THICK_W){1'b0}}, thick_q};
      end
      MUL_AREA_HI: begin
        mul_a = {{(MUL_A_W-HI_W){1'b0}}, area_q[AREA_W-1:LO_W]};
        mul_b = {{(MUL_B_W-THICK_W){1'b0}}, thick_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_comb begin
    cross_wide = {{(CROSS_X_W-CROSS_W){cross_q[CROSS_W-1]}}, cross_q}
               + {{(CROSS_X_W-MUL_P_W){p_q[MUL_P_W-1]}}, p_q}
               - {{(CROSS_X_W-MUL_P_W){mul_p[MUL_P_W-1]}}, mul_p};
    if (cross_wide[CROSS_X_W-1:CROSS_W-1] == '0 ||
        cross_wide[CROSS_X_W-1:CROSS_W-1] == '1) begin
      cross_d = cross_wide[CROSS_W-1:0];
    end else if (cross_wide[CROSS_X_W-1]) begin
      cross_d = CROSS_MIN;
    end else begin
      cross_d = CROSS_MAX;
    end
  end

  always_comb begin
    cross_mag = cross_q[CROSS_W-1] ? (~cross_q + 1'b1) : cross_q;
    half      = cross_mag[CROSS_W-1:1];
    area_d    = half[CROSS_W-2] ? AREA_MAX : half[AREA_W-1:0];
  end

  always_comb begin
    full = {mul_p[HI_W+THICK_W-1:0], {LO_W{1'b0}}}
         + {{(FULL_W-LO_W-THICK_W){1'b0}}, p_q[LO_W+THICK_W-1:0]};
    vp_d = (|full[FULL_W-1:VOL_W]) ? VOL_MAX : full[VOL_W-1:0];
  end

  always_comb begin
    vol_sum = {1'b0, vol_q} + {1'b0, vp_q};
    vol_d   = vol_sum[VOL_W] ? VOL_MAX : vol_sum[VOL_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vol_q <= '0;
    end else if (cmd_i.clr_vol) begin
      vol_q <= '0;
    end else if (cmd_i.vol_ld) begin
      vol_q <= vol_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_first) begin
      first_x_q <= coord_x_i;
      first_y_q <= coord_y_i;
      prev_x_q  <= coord_x_i;
      prev_y_q  <= coord_y_i;
      thick_q   <= thickness_i;
      cross_q   <= '0;
    end
    if (cmd_i.take_next) begin
      cur_x_q <= coord_x_i;
      cur_y_q <= coord_y_i;
    end
    if (cmd_i.p_ld) begin
      p_q <= mul_p;
    end
    if (cmd_i.cross_upd) begin
      cross_q  <= cross_d;
      prev_x_q <= cur_x_q;
      prev_y_q <= cur_y_q;
    end
    if (cmd_i.area_ld) begin
      area_q <= area_d;
    end
    if (cmd_i.vp_ld) begin
      vp_q <= vp_d;
    end
    if (cmd_i.vol_ld) begin
      area_out_q <= area_q;
      vol_out_q  <= vol_d;
    end
  end

  assign sts_o.closes    = (cur_x_q == first_x_q) && (cur_y_q == first_y_q);
  assign polygon_area_o  = area_out_q;
  assign volume_total_o  = vol_out_q;

endmodule

### hdl/pava_ctrl.sv
module pava_ctrl import pava_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  logic      clear_total_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output pava_cmd_t cmd_o,
  input  pava_sts_t sts_i
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CROSS = 3'd1;
  localparam logic [2:0] ST_AREA  = 3'd2;
  localparam logic [2:0] ST_MLO   = 3'd3;
  localparam logic [2:0] ST_MHI   = 3'd4;
  localparam logic [2:0] ST_ACC   = 3'd5;

  logic [2:0] state_q, state_d;
  logic       in_poly_q, in_poly_d;
  logic       out_valid_q, out_valid_d;
  logic       in_acc;
  logic       slot_free;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign slot_free  = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    in_poly_d   = in_poly_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    cmd_o.mul_sel = MUL_PX_Y;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          cmd_o.clr_vol = clear_total_i;
          if (!in_poly_q) begin
            cmd_o.take_first = 1'b1;
            in_poly_d        = 1'b1;
          end else begin
            cmd_o.take_next = 1'b1;
            cmd_o.p_ld      = 1'b1;
            state_d         = ST_CROSS;
          end
        end
      end
      ST_CROSS: begin
        cmd_o.mul_sel   = MUL_X_PY;
        cmd_o.cross_upd = 1'b1;
        if (sts_i.closes) begin
          in_poly_d = 1'b0;
          state_d   = ST_AREA;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_AREA: begin
        cmd_o.area_ld = 1'b1;
        state_d       = ST_MLO;
      end
      ST_MLO: begin
        cmd_o.mul_sel = MUL_AREA_LO;
        cmd_o.p_ld    = 1'b1;
        state_d       = ST_MHI;
      end
      ST_MHI: begin
        cmd_o.mul_sel = MUL_AREA_HI;
        cmd_o.vp_ld   = 1'b1;
        state_d       = ST_ACC;
      end
      ST_ACC: begin
        if (slot_free) begin
          cmd_o.vol_ld = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      in_poly_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      in_poly_q   <= in_poly_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### hdl/polygon_area_volume_accumulator_top.sv
// Result: out_valid_o rises once a closing vertex has passed the cross, area, low
// and high product and accumulate states, later while an earlier result waits to be
// taken. Input: taken only when idle; a first vertex leaves it in idle, later
// ones pass the cross state, a closing one all states, as the single multiplier is
// shared by both cross terms and the two halves of the area times thickness product.
// Reset: asynchronous, active low; clears the controller and the volume total.
`include "polygon_area_volume_accumulator_top_defines.svh"

module polygon_area_volume_accumulator_top import pava_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [COORD_W-1:0] coord_x_i,
  input  logic signed [COORD_W-1:0] coord_y_i,
  input  logic [THICK_W-1:0]        thickness_i,
  input  logic                      clear_total_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [AREA_W-1:0]         polygon_area_o,
  output logic [VOL_W-1:0]          volume_total_o
);

  pava_cmd_t cmd;
  pava_sts_t sts;

  pava_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .clear_total_i (clear_total_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .cmd_o         (cmd),
    .sts_i         (sts)
  );

  pava_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .coord_x_i      (coord_x_i),
    .coord_y_i      (coord_y_i),
    .thickness_i    (thickness_i),
    .polygon_area_o (polygon_area_o),
    .volume_total_o (volume_total_o)
  );

  `PAVA_ASSERT_SAME(a_no_overwrite, cmd.vol_ld, !out_valid_o || out_ready_i, "result overwritten")
  `PAVA_ASSERT_NEXT(a_cross_follows, cmd.take_next, cmd.cross_upd, "cross update missing")
  `PAVA_ASSERT_NEXT(a_close_to_area, cmd.cross_upd && sts.closes, cmd.area_ld, "area step missing")

endmodule

### verif/tb_polygon_area_volume_accumulator_top.sv
`timescale 1ns / 1ps

module tb_polygon_area_volume_accumulator_top;
  import pava_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 600000;
  localparam int unsigned RAND_ITEMS    = 440;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned WIND_LOOPS    = 10;
  localparam int unsigned TAIL_LIMIT    = 5000;
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam int unsigned DIR_ROWS      = 20;

  localparam logic signed [COORD_W-1:0] C_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic signed [COORD_W-1:0] C_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam longint CROSS_HI = (longint'(1) <<< (CROSS_W - 1)) - 1;
  localparam longint CROSS_LO = -CROSS_HI - 1;

  typedef struct packed {
    logic [AREA_W-1:0] area;
    logic [VOL_W-1:0]  vol;
  } area_vol_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [THICK_W-1:0]        thick;
    logic                      clr;
    logic                      typed;
    area_vol_t                 res;
  } stim_row_t;

  typedef enum int unsigned {
    SPAN_FULL,
    SPAN_NARROW,
    SPAN_EDGE,
    SPAN_COARSE
  } coord_span_e;

  logic                      clk_i         = 1'b0;
  logic                      rst_ni        = 1'b0;
  logic                      in_valid_i    = 1'b0;
  logic                      in_ready_o;
  logic signed [COORD_W-1:0] coord_x_i     = '0;
  logic signed [COORD_W-1:0] coord_y_i     = '0;
  logic [THICK_W-1:0]        thickness_i   = '0;
  logic                      clear_total_i = 1'b0;
  logic                      out_valid_o;
  logic                      out_ready_i   = 1'b0;
  logic [AREA_W-1:0]         polygon_area_o;
  logic [VOL_W-1:0]          volume_total_o;

  polygon_area_volume_accumulator_top i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .coord_x_i      (coord_x_i),
    .coord_y_i      (coord_y_i),
    .thickness_i    (thickness_i),
    .clear_total_i  (clear_total_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .polygon_area_o (polygon_area_o),
    .volume_total_o (volume_total_o)
  );

  always #5 clk_i = ~clk_i;

  logic                      poly_open  = 1'b0;
  logic signed [COORD_W-1:0] anchor_x   = '0;
  logic signed [COORD_W-1:0] anchor_y   = '0;
  logic signed [COORD_W-1:0] last_x     = '0;
  logic signed [COORD_W-1:0] last_y     = '0;
  logic [THICK_W-1:0]        poly_thick = '0;
  longint                    twice_area = 0;
  logic [VOL_W-1:0]          vol_sum    = '0;

  area_vol_t   areas_due [$];
  int unsigned failures      = 0;
  int unsigned vertices_sent = 0;
  int unsigned areas_checked = 0;
  int unsigned cross_clips   = 0;
  int unsigned area_clips    = 0;
  int unsigned total_pins    = 0;
  int unsigned hold_len      = 0;
  int unsigned cycles        = 0;
  logic        calm          = 1'b0;

  stim_row_t dir_tab [DIR_ROWS] = '{
    '{24'sd0,    24'sd0,     16'h0100, 1'b0, 1'b0, '0},
    '{24'sd0,    24'sd0,     16'h0100, 1'b0, 1'b1, '{57'd0, 63'd0}},
    '{C_MIN,     C_MIN,      16'hFFFF, 1'b1, 1'b0, '0},
    '{C_MAX,     C_MIN,      16'h0000, 1'b0, 1'b0, '0},
    '{C_MAX,     C_MAX,      16'hFFFF, 1'b0, 1'b0, '0},
    '{C_MIN,     C_MAX,      16'h0000, 1'b0, 1'b0, '0},
    '{C_MIN,     C_MIN,      16'h0000, 1'b0, 1'b1, '{57'h0_FFFF_FE00_0001, VOL_MAX}},
    '{24'sd1,    24'sd0,     16'h0100, 1'b1, 1'b0, '0},
    '{24'sd0,    24'sd1,     16'h0000, 1'b0, 1'b0, '0},
    '{24'sd0,    24'sd0,     16'h0000, 1'b0, 1'b0, '0},
    '{24'sd1,    24'sd0,     16'h0000, 1'b0, 1'b1, '{57'd0, 63'd0}},
    '{C_MAX,     C_MAX,      16'h0000, 1'b0, 1'b0, '0},
    '{24'sd0,    C_MAX,      16'hA5A5, 1'b1, 1'b0, '0},
    '{24'sd0,    C_MIN,      16'h5A5A, 1'b0, 1'b0, '0},
    '{C_MAX,     C_MAX,      16'hFFFF, 1'b0, 1'b0, '0},
    '{C_MIN,     24'sd0,     16'h8001, 1'b0, 1'b0, '0},
    '{-24'sd5,   24'sd7,     16'h0000, 1'b0, 1'b0, '0},
    '{24'sd300,  -24'sd1234, 16'h0000, 1'b0, 1'b0, '0},
    '{C_MIN,     24'sd5,     16'h0000, 1'b0, 1'b0, '0},
    '{C_MIN,     24'sd0,     16'h0000, 1'b1, 1'b0, '0}
  };

  task automatic note_failure(input string what, input logic [63:0] want_v,
                              input logic [63:0] got_v);
    if (failures < 10) begin
      $display("mismatch %s: expected %0d, got %0d", what, want_v, got_v);
    end
    failures++;
  endtask

  task automatic shoelace_step(input logic signed [COORD_W-1:0] x,
                               input logic signed [COORD_W-1:0] y,
                               input logic [THICK_W-1:0] thick, input logic clr,
                               output logic closed, output area_vol_t res);
    longint            term;
    longint            sum;
    logic [63:0]       mag;
    logic [63:0]       half;
    logic [AREA_W-1:0] area;
    logic [127:0]      prod;
    logic [VOL_W:0]    room;
    closed = 1'b0;
    res    = '0;
    if (clr) vol_sum = '0;
    if (!poly_open) begin
      anchor_x   = x;
      anchor_y   = y;
      last_x     = x;
      last_y     = y;
      poly_thick = thick;
      twice_area = 0;
      poly_open  = 1'b1;
      return;
    end
    term = longint'(last_x) * longint'(y) - longint'(x) * longint'(last_y);
    sum  = twice_area + term;
    if (sum > CROSS_HI) begin
      sum = CROSS_HI;
      cross_clips++;
    end else if (sum < CROSS_LO) begin
      sum = CROSS_LO;
      cross_clips++;
    end
    twice_area = sum;
    last_x     = x;
    last_y     = y;
    if (x != anchor_x || y != anchor_y) return;
    poly_open = 1'b0;
    closed    = 1'b1;
    mag  = (twice_area < 0) ? 64'(-twice_area) : 64'(twice_area);
    half = mag >> 1;
    if (half > 64'(AREA_MAX)) begin
      area = AREA_MAX;
      area_clips++;
    end else begin
      area = half[AREA_W-1:0];
    end
    prod = 128'(area) * 128'(poly_thick);
    if (prod > 128'(VOL_MAX)) prod = 128'(VOL_MAX);
    room = {1'b0, vol_sum} + {1'b0, prod[VOL_W-1:0]};
    if (room > {1'b0, VOL_MAX}) begin
      vol_sum = VOL_MAX;
      total_pins++;
    end else begin
      vol_sum = room[VOL_W-1:0];
    end
    res.area = area;
    res.vol  = vol_sum;
  endtask

  task automatic offer_vertex(input logic signed [COORD_W-1:0] x,
                              input logic signed [COORD_W-1:0] y,
                              input logic [THICK_W-1:0] thick, input logic clr,
                              input logic typed, input area_vol_t typed_res);
    int unsigned gap;
    logic        closed;
    area_vol_t   res;
    gap = calm ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    coord_x_i     <= x;
    coord_y_i     <= y;
    thickness_i   <= thick;
    clear_total_i <= clr;
    do @(posedge clk_i); while (!in_ready_o);
    shoelace_step(x, y, thick, clr, closed, res);
    if (typed) areas_due = {areas_due, typed_res};
    else if (closed) areas_due = {areas_due, res};
    vertices_sent++;
  endtask

  function automatic logic signed [COORD_W-1:0] draw_coord(input coord_span_e span);
    logic [31:0] r;
    r = $urandom;
    case (span)
      SPAN_NARROW: return COORD_W'(int'(r[9:0]) - 512);
      SPAN_EDGE:   return r[1] ? (r[0] ? C_MAX : C_MIN) : (r[0] ? '1 : '0);
      SPAN_COARSE: return {r[COORD_W-1:12], 12'h000};
      default:     return r[COORD_W-1:0];
    endcase
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : drain_results
    int unsigned stall;
    area_vol_t   got;
    area_vol_t   want;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      if (hold_len != 0) begin
        stall    = hold_len;
        hold_len = 0;
      end else begin
        stall = calm ? 0 : $urandom_range(0, 4);
      end
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      got.area = polygon_area_o;
      got.vol  = volume_total_o;
      if (areas_due.size() == 0) begin
        note_failure("area with no polygon pending", '0, 64'(got.area));
      end else begin
        want = areas_due.pop_front();
        if (got.area != want.area) note_failure("polygon_area", 64'(want.area), 64'(got.area));
        if (got.vol != want.vol) note_failure("volume_total", 64'(want.vol), 64'(got.vol));
        areas_checked++;
      end
    end
  end

  initial begin : feed_vertices
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [THICK_W-1:0]        thick;
    logic                      clr;
    coord_span_e               span;
    int unsigned               left;
    int unsigned               rand_sent;
    int unsigned               tail;
    int                        corner;
    logic                      paused;
    span      = SPAN_FULL;
    left      = 0;
    rand_sent = 0;
    paused    = 1'b0;
    thick     = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      offer_vertex(dir_tab[i].x, dir_tab[i].y, dir_tab[i].thick, dir_tab[i].clr,
                   dir_tab[i].typed, dir_tab[i].res);
    end

    while (rand_sent < RAND_ITEMS) begin
      if (rand_sent == 120) hold_len = HOLD_CYCLES;
      calm = (rand_sent >= 250 && rand_sent < 330);
      if (!poly_open) begin
        if (rand_sent >= 400 && !paused) begin
          in_valid_i <= 1'b0;
          do @(posedge clk_i); while (areas_due.size() != 0);
          paused = 1'b1;
        end
        span = coord_span_e'($urandom_range(0, 3));
        left = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(2, 7);
        if ($urandom_range(0, 15) == 0) left = $urandom_range(10, 30);
        x = draw_coord(span);
        y = draw_coord(span);
        case ($urandom_range(0, 5))
          0:       thick = '0;
          1:       thick = '1;
          default: thick = THICK_W'($urandom);
        endcase
      end else if (left == 0) begin
        x     = anchor_x;
        y     = anchor_y;
        thick = THICK_W'($urandom);
      end else begin
        left--;
        x     = draw_coord(span);
        y     = draw_coord(span);
        thick = THICK_W'($urandom);
        case ($urandom_range(0, 9))
          0:       x = anchor_x;
          1:       y = anchor_y;
          default: ;
        endcase
      end
      clr = ($urandom_range(0, 7) == 0);
      offer_vertex(x, y, thick, clr, 1'b0, '0);
      rand_sent++;
    end

    calm = 1'b0;
    if (poly_open) offer_vertex(anchor_x, anchor_y, '0, 1'b0, 1'b0, '0);
    // wind the full square one way, then the other
    for (int turn = 0; turn < 2; turn++) begin
      calm = (turn == 1);
      offer_vertex('0, '0, THICK_W'($urandom), 1'b1, 1'b0, '0);
      for (int k = 0; k < 4 * WIND_LOOPS; k++) begin
        corner = (turn == 1) ? 3 - k % 4 : k % 4;
        x = (corner == 1 || corner == 2) ? C_MAX - COORD_W'($urandom_range(0, 15))
                                         : C_MIN + COORD_W'($urandom_range(0, 15));
        y = (corner >= 2) ? C_MAX - COORD_W'($urandom_range(0, 15))
                          : C_MIN + COORD_W'($urandom_range(0, 15));
        offer_vertex(x, y, THICK_W'($urandom), ($urandom_range(0, 63) == 0), 1'b0, '0);
      end
      offer_vertex('0, '0, THICK_W'($urandom), 1'b0, 1'b0, '0);
    end
    calm = 1'b0;

    in_valid_i <= 1'b0;
    tail = 0;
    while (areas_due.size() != 0 && tail < TAIL_LIMIT) begin
      @(posedge clk_i);
      tail++;
    end
    if (areas_due.size() != 0) note_failure("areas still owed", '0, 64'(areas_due.size()));
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("sent %0d vertices, checked %0d closed polygons", vertices_sent, areas_checked);
    $display("cross sum clipped %0d times, area clipped %0d times, total pinned %0d times",
             cross_clips, area_clips, total_pins);
    if (failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### polygon_area_volume_accumulator_top.f
+incdir+hdl
hdl/pava_pkg.sv
hdl/pava_dp.sv
hdl/pava_ctrl.sv
hdl/polygon_area_volume_accumulator_top.sv
verif/tb_polygon_area_volume_accumulator_top.sv
